[sv/hf2u8_pkg.sv]
// ----------------------------------------------------------------------------
// hf2u8_pkg
// Shared types and constants for the half-float to unorm8 rgb converter.
// ----------------------------------------------------------------------------
package hf2u8_pkg;

    // binary16 field widths
    localparam int HALF_W = 16;
    localparam int EXP_W  = 5;
    localparam int MANT_W = 10;
    localparam int BYTE_W = 8;

    // exponent codes
    localparam logic [EXP_W-1:0] HALF_EXP_MAX  = 5'h1F;
    localparam logic [EXP_W-1:0] HALF_EXP_ZERO = 5'h00;
    localparam logic [EXP_W-1:0] HALF_EXP_ONE  = 5'd15;

    // scale shift: normal k = 25 - e, subnormal k = 24
    localparam logic [EXP_W-1:0] SHIFT_BIAS     = 5'd25;
    localparam logic [EXP_W-1:0] SHIFT_SUBNORM  = 5'd24;

    // saturated outputs
    localparam logic [BYTE_W-1:0] UNORM_MAX  = 8'hFF;
    localparam logic [BYTE_W-1:0] UNORM_ZERO = 8'h00;

    // one converted pixel
    typedef struct packed {
        logic [BYTE_W-1:0] blue_byte;
        logic [BYTE_W-1:0] green_byte;
        logic [BYTE_W-1:0] red_byte;
    } rgb8_t;

endpackage

[sv/half_float_to_unorm8_rgb_unit.sv]
// ----------------------------------------------------------------------------
// half_float_to_unorm8_rgb_unit
// Converts an rgb pixel of binary16 channels to three 8-bit unorm channels.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one pixel per transaction: red, green and blue binary16
//   words packed in tdata. m_axis returns one transaction per pixel with the
//   three converted bytes. Each channel is clamped to [0,1] and mapped to
//   floor(v*255 + 0.5); negatives, -inf and nan give 0, values of one or
//   more and +inf give 255.
//   Three identical lanes convert the channels side by side, combinationally;
//   the merge stage registers the pixel, so m_axis_tvalid rises with the
//   accepting edge, and throughput is one pixel per clock while m_axis_tready is high.
//   When the receiver stalls, the output register holds its pixel and
//   s_axis_tready drops until that pixel is taken; s_axis_tready follows
//   m_axis_tready while the register is full.
//   Reset (aresetn low, synchronous) empties the output register; the block
//   is ready again in the first cycle after reset.
// ----------------------------------------------------------------------------
module half_float_to_unorm8_rgb_unit
    import hf2u8_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,   // red_half [15:0], green_half [31:16], blue_half [47:32]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata    // red_byte [7:0], green_byte [15:8], blue_byte [23:16]
);

    logic [BYTE_W-1:0] red_lane;
    logic [BYTE_W-1:0] green_lane;
    logic [BYTE_W-1:0] blue_lane;
    rgb8_t             pixel;

    // one conversion lane per channel
    hf2u8_lane u_lane_red (
        .half_in  (s_axis_tdata[15:0]),
        .byte_out (red_lane)
    );

    hf2u8_lane u_lane_green (
        .half_in  (s_axis_tdata[31:16]),
        .byte_out (green_lane)
    );

    hf2u8_lane u_lane_blue (
        .half_in  (s_axis_tdata[47:32]),
        .byte_out (blue_lane)
    );

    // merge and output register
    hf2u8_merge u_merge (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .red_lane   (red_lane),
        .green_lane (green_lane),
        .blue_lane  (blue_lane),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_pixel  (pixel)
    );

    assign m_axis_tdata = pixel;

endmodule

[sv/hf2u8_lane.sv]
// ----------------------------------------------------------------------------
// hf2u8_lane
// One channel: binary16 to 8-bit unorm, clamped to [0,1], rounded half up.
// ----------------------------------------------------------------------------
module hf2u8_lane
    import hf2u8_pkg::*;
(
    input  logic [HALF_W-1:0] half_in,
    output logic [BYTE_W-1:0] byte_out
);

    logic              sign;
    logic [EXP_W-1:0]  expo;
    logic [MANT_W-1:0] mant;
    logic [MANT_W:0]   sig;
    logic [EXP_W-1:0]  shift;
    logic [18:0]       prod;
    logic [23:0]       sum;
    logic [23:0]       scaled;

    assign sign = half_in[15];
    assign expo = half_in[14:10];
    assign mant = half_in[9:0];

    // significand and scale shift for finite values
    always_comb begin
        if (expo == HALF_EXP_ZERO) begin
            sig   = {1'b0, mant};
            shift = SHIFT_SUBNORM;
        end else begin
            sig   = {1'b1, mant};
            shift = SHIFT_BIAS - expo;
        end
    end

    // sig * 255 as a shift and subtract, then add half an lsb and scale down
    assign prod   = {sig, 8'h00} - {8'h00, sig};
    assign sum    = {5'b0, prod} + (24'd1 << (shift - 5'd1));
    assign scaled = sum >> shift;

    // special cases first, then the scaled value
    always_comb begin
        if (expo == HALF_EXP_MAX) begin
            byte_out = (mant == '0 && !sign) ? UNORM_MAX : UNORM_ZERO;
        end else if (expo == HALF_EXP_ZERO && mant == '0) begin
            byte_out = UNORM_ZERO;
        end else if (sign) begin
            byte_out = UNORM_ZERO;
        end else if (expo >= HALF_EXP_ONE) begin
            byte_out = UNORM_MAX;
        end else begin
            byte_out = scaled[BYTE_W-1:0];
        end
    end

endmodule

[sv/hf2u8_merge.sv]
// ----------------------------------------------------------------------------
// hf2u8_merge
// Gathers the three lane bytes into one pixel and holds it in the output
// register until the receiver takes it.
// ----------------------------------------------------------------------------
module hf2u8_merge
    import hf2u8_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [BYTE_W-1:0] red_lane,
    input  logic [BYTE_W-1:0] green_lane,
    input  logic [BYTE_W-1:0] blue_lane,
    output logic              out_valid,
    input  logic              out_ready,
    output rgb8_t             out_pixel
);

    logic  valid_reg;
    logic  valid_next;
    rgb8_t pixel_reg;
    rgb8_t pixel_next;

    // the register takes a new pixel when empty or being drained
    assign in_ready = !valid_reg || out_ready;

    always_comb begin
        valid_next = valid_reg;
        pixel_next = pixel_reg;
        if (in_ready) begin
            valid_next = in_valid;
            pixel_next = '{blue_byte: blue_lane, green_byte: green_lane, red_byte: red_lane};
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        pixel_reg <= pixel_next;
    end

    assign out_valid = valid_reg;
    assign out_pixel = pixel_reg;

endmodule

[verif/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the half-float to unorm8 rgb converter: a directed
// table of special values and extremes, then random pixels, with random gaps
// on the pixel input and random stalls on the result output.
// ----------------------------------------------------------------------------
module testbench
    import hf2u8_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_PIXELS = 1950;
    localparam int CYCLE_LIMIT   = 1000000;
    localparam int DRAIN_CYCLES  = 8;

    // one directed row: three binary16 words, and a typed pixel where it is known
    typedef struct packed {
        logic [HALF_W-1:0] red;
        logic [HALF_W-1:0] green;
        logic [HALF_W-1:0] blue;
        logic              known;
        logic [23:0]       pixel;   // blue [23:16], green [15:8], red [7:0]
    } pixel_case_t;

    localparam int NUM_CASES = 21;

    pixel_case_t directed_cases [0:NUM_CASES-1] = '{
        // zeros, ones, signed zero and infinities
        '{16'h0000, 16'h0000, 16'h0000, 1'b1, 24'h000000},
        '{16'h3C00, 16'h3C00, 16'h3C00, 1'b1, 24'hFFFFFF},
        '{16'h8000, 16'h7C00, 16'hFC00, 1'b1, 24'h00FF00},
        // nan, quiet and signaling, any sign
        '{16'h7E00, 16'hFFFF, 16'h7C01, 1'b1, 24'h000000},
        '{16'hFE00, 16'h7DFF, 16'hFC01, 1'b1, 24'h000000},
        // largest finite magnitudes, just above one
        '{16'h7BFF, 16'hFBFF, 16'h3C01, 1'b1, 24'hFF00FF},
        // smallest and largest subnormals, negative subnormal
        '{16'h0001, 16'h03FF, 16'h8001, 1'b1, 24'h000000},
        // the tie at one half rounds up, negative half clamps
        '{16'h3800, 16'h3800, 16'hB800, 1'b1, 24'h008080},
        '{16'hBC00, 16'h7FFF, 16'h7C00, 1'b1, 24'hFF0000},
        '{16'h4000, 16'hC000, 16'h5BFF, 1'b1, 24'hFF00FF},
        '{16'h8400, 16'h83FF, 16'hF000, 1'b1, 24'h000000},
        '{16'h3C00, 16'h0000, 16'h7BFF, 1'b1, 24'hFF00FF},
        '{16'h5555, 16'hAAAA, 16'h0000, 1'b1, 24'h0000FF},
        // in-range values, checked against the predictor
        '{16'h3BFF, 16'h0400, 16'h3555, 1'b0, 24'h000000},
        '{16'h2000, 16'h1C00, 16'h3400, 1'b0, 24'h000000},
        '{16'h3A00, 16'h3600, 16'h3000, 1'b0, 24'h000000},
        '{16'h0200, 16'h0100, 16'h1E66, 1'b0, 24'h000000},
        '{16'h2C00, 16'h2E00, 16'h3B00, 1'b0, 24'h000000},
        '{16'h3BFE, 16'h3BF0, 16'h3B80, 1'b0, 24'h000000},
        '{16'h1800, 16'h1FFF, 16'h2400, 1'b0, 24'h000000},
        '{16'h37FF, 16'h3801, 16'h3AAA, 1'b0, 24'h000000}
    };

    // values that sit on the edges of the mapping
    localparam int NUM_EDGE_HALVES = 12;
    localparam logic [HALF_W-1:0] EDGE_HALVES [0:NUM_EDGE_HALVES-1] = '{
        16'h0000, 16'h8000, 16'h3C00, 16'h3BFF, 16'h3C01, 16'h3800,
        16'h7C00, 16'hFC00, 16'h7E00, 16'h0001, 16'h03FF, 16'h0400
    };

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata = '0;    // red_half [15:0], green_half [31:16], blue_half [47:32]
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;         // red_byte [7:0], green_byte [15:8], blue_byte [23:16]

    rgb8_t expected_pixels [$];
    int    error_count = 0;
    int    cycle_count = 0;
    bit    source_steady = 1'b0;
    bit    sink_steady = 1'b0;
    int    stall_left = 0;

    half_float_to_unorm8_rgb_unit uut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // clock
    initial begin
        forever #2 aclk = ~aclk;
    end

    // exact clamp, scale by 255 and round half up of one binary16 word
    function automatic logic [BYTE_W-1:0] unorm8_from_half(input logic [HALF_W-1:0] h);
        logic [EXP_W-1:0]  ex;
        logic [MANT_W-1:0] man;
        logic [MANT_W:0]   sig;
        int                shift;
        logic [31:0]       scaled;
        ex  = h[14:10];
        man = h[MANT_W-1:0];
        if (ex == HALF_EXP_MAX)
            return (man == '0 && !h[15]) ? UNORM_MAX : UNORM_ZERO;
        if (ex == HALF_EXP_ZERO && man == '0)
            return UNORM_ZERO;
        if (h[15])
            return UNORM_ZERO;
        if (ex >= HALF_EXP_ONE)
            return UNORM_MAX;
        if (ex == HALF_EXP_ZERO) begin
            sig   = {1'b0, man};
            shift = int'(SHIFT_SUBNORM);
        end else begin
            sig   = {1'b1, man};
            shift = int'(SHIFT_BIAS) - int'(ex);
        end
        scaled = (32'(sig) * 32'(UNORM_MAX) + (32'd1 << (shift - 1))) >> shift;
        return scaled[BYTE_W-1:0];
    endfunction

    function automatic rgb8_t convert_pixel(input logic [47:0] word);
        rgb8_t px;
        px.red_byte   = unorm8_from_half(word[15:0]);
        px.green_byte = unorm8_from_half(word[31:16]);
        px.blue_byte  = unorm8_from_half(word[47:32]);
        return px;
    endfunction

    // random channel word, weighted toward the interesting part of [0,1]
    function automatic logic [HALF_W-1:0] random_half();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 35)
            return HALF_W'($urandom_range(0, 65535));
        else if (pick < 70)
            return {1'b0, EXP_W'($urandom_range(0, 14)), MANT_W'($urandom)};
        else if (pick < 80)
            return {1'b0, HALF_EXP_ZERO, MANT_W'($urandom)};
        else if (pick < 90)
            return {1'b0, EXP_W'($urandom_range(13, 14)), MANT_W'($urandom)};
        else
            return EDGE_HALVES[$urandom_range(0, NUM_EDGE_HALVES - 1)];
    endfunction

    // idle stretch length: mostly short, now and then long
    function automatic int idle_length();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 75)
            return $urandom_range(1, 3);
        else if (pick < 95)
            return $urandom_range(4, 12);
        else
            return $urandom_range(20, 40);
    endfunction

    // present one pixel, wait for the transaction, then record its expectation
    task automatic send_pixel(input logic [47:0] word, input rgb8_t want);
        int gap;
        gap = (source_steady || $urandom_range(0, 99) < 60) ? 0 : idle_length();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= word;
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
        expected_pixels.push_back(want);
    endtask

    // result side back-pressure
    always @(posedge aclk) begin
        if (stall_left > 0) begin
            stall_left    <= stall_left - 1;
            m_axis_tready <= 1'b0;
        end else if (!sink_steady && $urandom_range(0, 99) < 20) begin
            stall_left    <= idle_length() - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
        if ($urandom_range(0, 299) == 0)
            sink_steady <= ~sink_steady;
    end

    // compare each result transaction with the oldest expectation
    always @(posedge aclk) begin : result_check
        rgb8_t got;
        rgb8_t want;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            got = m_axis_tdata;
            if (expected_pixels.size() == 0) begin
                $error("unexpected result transaction: %h", m_axis_tdata);
                error_count++;
            end else begin
                want = expected_pixels.pop_front();
                if (got.red_byte !== want.red_byte) begin
                    $error("red_byte: expected %h, got %h", want.red_byte, got.red_byte);
                    error_count++;
                end
                if (got.green_byte !== want.green_byte) begin
                    $error("green_byte: expected %h, got %h", want.green_byte,
                           got.green_byte);
                    error_count++;
                end
                if (got.blue_byte !== want.blue_byte) begin
                    $error("blue_byte: expected %h, got %h", want.blue_byte, got.blue_byte);
                    error_count++;
                end
            end
        end
    end

    // watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // stimulus
    initial begin : stimulus
        logic [47:0] word;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed table
        for (int i = 0; i < NUM_CASES; i++) begin
            word = {directed_cases[i].blue, directed_cases[i].green, directed_cases[i].red};
            send_pixel(word, directed_cases[i].known ? rgb8_t'(directed_cases[i].pixel)
                                                     : convert_pixel(word));
        end

        // random pixels, with runs of back-to-back transactions
        for (int i = 0; i < RANDOM_PIXELS; i++) begin
            if (i % 64 == 0)
                source_steady = ($urandom_range(0, 3) == 0);
            word = {random_half(), random_half(), random_half()};
            send_pixel(word, convert_pixel(word));
        end
        s_axis_tvalid <= 1'b0;

        // drain
        while (expected_pixels.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (error_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

[files.f]
sv/hf2u8_pkg.sv
sv/hf2u8_lane.sv
sv/hf2u8_merge.sv
sv/half_float_to_unorm8_rgb_unit.sv
verif/testbench.sv
